>>> hdl/pfe_pkg.sv
// -----------------------------------------------------------------------------
// pfe_pkg
// Shared types, constants and the RGB555 blend function of the palette fade
// engine.
// -----------------------------------------------------------------------------
package pfe_pkg;

   localparam int SLOT_COUNT_DEF = 16;
   localparam int MASK_W         = 16;
   localparam int CHAN_W         = 5;
   localparam int COLOR_W        = 15;
   localparam int LEVEL_W        = 5;
   localparam int SPEED_W        = 7;
   localparam int STEP_W         = 7;
   localparam int DELAY_W        = 6;
   localparam int SLOT_W         = 4;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 16;

   localparam logic [CHAN_W-1:0] CHAN_MAX  = 5'h1f;
   localparam logic [STEP_W-1:0] BASE_STEP = 7'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_COLOR = 3'd0,
      CSR_START_LEVEL  = 3'd1,
      CSR_END_LEVEL    = 3'd2,
      CSR_FADE_SPEED   = 3'd3,
      CSR_SLOT_MASK    = 3'd4
   } csr_index_type;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_TICK  = 1'b1
   } cmd_type;

   // c + floor((t - c) * lv / 16), saturated to the channel range
   function automatic logic [CHAN_W-1:0] mix_channel(input logic [CHAN_W-1:0]  c,
                                                      input logic [CHAN_W-1:0]  t,
                                                      input logic [LEVEL_W-1:0] lv);
      logic signed [5:0]  d;
      logic signed [11:0] p;
      logic signed [7:0]  q;
      logic signed [8:0]  r;
      d = $signed({1'b0, t}) - $signed({1'b0, c});
      p = 12'(d) * $signed({7'b0, lv});
      q = 8'(p >>> 4);
      r = 9'(q) + $signed({4'b0, c});
      if (r < 0) begin
         return '0;
      end else if (r > $signed({4'b0, CHAN_MAX})) begin
         return CHAN_MAX;
      end else begin
         return r[CHAN_W-1:0];
      end
   endfunction

   function automatic logic [COLOR_W-1:0] mix_color(input logic [COLOR_W-1:0] src,
                                                    input logic [COLOR_W-1:0] tgt,
                                                    input logic [LEVEL_W-1:0] lv);
      return {mix_channel(src[14:10], tgt[14:10], lv),
              mix_channel(src[9:5],   tgt[9:5],   lv),
              mix_channel(src[4:0],   tgt[4:0],   lv)};
   endfunction

endpackage

>>> hdl/palette_fade_engine.sv
// -----------------------------------------------------------------------------
// palette_fade_engine
// Fades a streamed RGB555 palette to a target colour, one word per cycle if not stalled.
// -----------------------------------------------------------------------------
// Colours arrive as passes closed by tlast; the first word of a pass decides
// whether the pass blends (start or expired tick). Each word is blended in a
// single combinational pass (three 6x5 multiplies) and lands in the result
// register, so one word is accepted every cycle while the
// result side takes words. Settings are latched from the registers when a
// start pass begins; register writes leave a running fade untouched.
module palette_fade_engine #(
   parameter int SLOT_COUNT = pfe_pkg::SLOT_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // configuration
   input  logic                             csr_we,
   input  logic [pfe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pfe_pkg::CSR_DATA_W-1:0]   csr_wdata,
   // input stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [23:0]                      req_tdata,  // slot[3:0], source_color[18:4]
   input  logic                             req_tuser,  // cmd
   input  logic                             req_tlast,  // pass_end
   // result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [15:0]                      rsp_tdata,  // blended_color[14:0]
   output logic [2:0]                       rsp_tuser,  // written, fade_done, fade_active
   output logic                             rsp_tlast   // last_out
);

   localparam int LW = pfe_pkg::LEVEL_W;
   localparam int SW = pfe_pkg::STEP_W;
   localparam int DW = pfe_pkg::DELAY_W;
   localparam int CW = pfe_pkg::COLOR_W;

   // configuration registers
   logic [CW-1:0]                  target_color_ff;
   logic [LW-1:0]                  start_level_ff;
   logic [LW-1:0]                  end_level_ff;
   logic [pfe_pkg::SPEED_W-1:0]    fade_speed_ff;
   logic [pfe_pkg::MASK_W-1:0]     slot_mask_ff;

   // fade state
   logic                  active_ff, active_in;
   logic [LW-1:0]         level_ff, level_in;
   logic [DW-1:0]         delay_count_ff, delay_count_in;
   logic                  in_pass_ff, in_pass_in;
   logic                  blend_pass_ff, blend_pass_in;
   logic [CW-1:0]         lat_target_ff, lat_target_in;
   logic [LW-1:0]         lat_end_ff, lat_end_in;
   logic [SW-1:0]         lat_step_ff, lat_step_in;
   logic [DW-1:0]         lat_delay_ff, lat_delay_in;
   logic                  lat_down_ff, lat_down_in;
   logic [SLOT_COUNT-1:0] lat_mask_ff, lat_mask_in;

   // result register
   logic                  rsp_valid_ff;
   logic [CW-1:0]         color_ff, color_in;
   logic                  written_ff, written_in;
   logic                  last_ff;
   logic                  done_ff, done_in;
   logic                  act_out_ff;

   logic                  accept;
   logic [pfe_pkg::SLOT_W-1:0] slot;
   logic [CW-1:0]         src;
   logic                  first;
   logic                  start_fire;
   logic                  bp;
   logic [SW-1:0]         new_step;
   logic [DW-1:0]         new_delay;
   logic [pfe_pkg::MASK_W-1:0] mask_wide;
   logic [7:0]            level_up;
   logic [7:0]            end_plus;

   assign slot   = req_tdata[3:0];
   assign src    = req_tdata[18:4];
   assign accept = req_tvalid && req_tready;

   assign req_tready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_color_ff <= '0;
         start_level_ff  <= '0;
         end_level_ff    <= '0;
         fade_speed_ff   <= '0;
         slot_mask_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            pfe_pkg::CSR_TARGET_COLOR: target_color_ff <= csr_wdata[CW-1:0];
            pfe_pkg::CSR_START_LEVEL:  start_level_ff  <= csr_wdata[LW-1:0];
            pfe_pkg::CSR_END_LEVEL:    end_level_ff    <= csr_wdata[LW-1:0];
            pfe_pkg::CSR_FADE_SPEED:   fade_speed_ff   <= csr_wdata[pfe_pkg::SPEED_W-1:0];
            pfe_pkg::CSR_SLOT_MASK:    slot_mask_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // settings derived from the speed register at start
   always_comb begin
      if (fade_speed_ff[pfe_pkg::SPEED_W-1]) begin
         new_step  = pfe_pkg::BASE_STEP + (~fade_speed_ff + 7'd1);
         new_delay = '0;
      end else begin
         new_step  = pfe_pkg::BASE_STEP;
         new_delay = fade_speed_ff[DW-1:0];
      end
   end

   always_comb begin
      first      = !in_pass_ff;
      start_fire = first && (req_tuser == pfe_pkg::CMD_START) && !active_ff;

      active_in      = active_ff;
      level_in       = level_ff;
      delay_count_in = delay_count_ff;
      lat_target_in  = lat_target_ff;
      lat_end_in     = lat_end_ff;
      lat_step_in    = lat_step_ff;
      lat_delay_in   = lat_delay_ff;
      lat_down_in    = lat_down_ff;
      lat_mask_in    = lat_mask_ff;
      bp             = blend_pass_ff;
      done_in        = 1'b0;

      if (first) begin
         bp = 1'b0;
         if (req_tuser == pfe_pkg::CMD_START) begin
            if (start_fire) begin
               lat_step_in    = new_step;
               lat_delay_in   = new_delay;
               lat_target_in  = target_color_ff;
               lat_end_in     = end_level_ff;
               lat_down_in    = !(start_level_ff < end_level_ff);
               lat_mask_in    = slot_mask_ff[SLOT_COUNT-1:0];
               level_in       = start_level_ff;
               delay_count_in = new_delay;
               active_in      = 1'b1;
               bp             = 1'b1;
            end
         end else if (active_ff) begin
            if (delay_count_ff < lat_delay_ff) begin
               delay_count_in = delay_count_ff + 6'd1;
            end else begin
               delay_count_in = '0;
               bp             = 1'b1;
            end
         end
      end

      // blend with the settings in force for this word
      mask_wide  = pfe_pkg::MASK_W'(lat_mask_in);
      written_in = bp && mask_wide[slot];
      color_in   = written_in ? pfe_pkg::mix_color(src, lat_target_in, level_in) : '0;

      level_up = 8'(level_in) + 8'(lat_step_in);
      end_plus = 8'(lat_end_in) + 8'(lat_step_in);

      if (req_tlast && bp) begin
         if (level_in == lat_end_in) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end else if (!lat_down_in) begin
            level_in = (level_up > 8'(lat_end_in)) ? lat_end_in : level_up[LW-1:0];
         end else begin
            level_in = (8'(level_in) < end_plus) ? lat_end_in
                                                 : LW'(level_in - LW'(lat_step_in));
         end
      end

      in_pass_in    = !req_tlast;
      blend_pass_in = req_tlast ? 1'b0 : bp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b0;
         level_ff       <= '0;
         delay_count_ff <= '0;
         in_pass_ff     <= 1'b0;
         blend_pass_ff  <= 1'b0;
         lat_target_ff  <= '0;
         lat_end_ff     <= '0;
         lat_step_ff    <= '0;
         lat_delay_ff   <= '0;
         lat_down_ff    <= 1'b0;
         lat_mask_ff    <= '0;
      end else if (accept) begin
         active_ff      <= active_in;
         level_ff       <= level_in;
         delay_count_ff <= delay_count_in;
         in_pass_ff     <= in_pass_in;
         blend_pass_ff  <= blend_pass_in;
         lat_target_ff  <= lat_target_in;
         lat_end_ff     <= lat_end_in;
         lat_step_ff    <= lat_step_in;
         lat_delay_ff   <= lat_delay_in;
         lat_down_ff    <= lat_down_in;
         lat_mask_ff    <= lat_mask_in;
      end
   end

   // result register: load on accept, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         color_ff   <= color_in;
         written_ff <= written_in;
         last_ff    <= req_tlast;
         done_ff    <= done_in;
         act_out_ff <= active_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, color_ff};
   assign rsp_tuser  = {act_out_ff, done_ff, written_ff};
   assign rsp_tlast  = last_ff;

endmodule

>>> tb/tb_palette_fade_engine.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_palette_fade_engine
// Self-checking bench for the palette fade engine. Passes of colour words are
// queued per phase and handed to the block in bursts. Each accepted word is
// run through a local fade predictor, and every result word is checked field
// by field against the oldest prediction while the result side stalls on its
// own pattern, with occasional long hold-offs.
// -----------------------------------------------------------------------------
module tb_palette_fade_engine;

   localparam int SLOTS       = pfe_pkg::SLOT_COUNT_DEF;
   localparam int RANDOM_WORDS = 1150;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      pfe_pkg::cmd_type                cmd;
      logic [pfe_pkg::SLOT_W-1:0]      slot;
      logic [pfe_pkg::COLOR_W-1:0]     color;
      logic                            last;
   } pass_word_type;

   typedef struct packed {
      logic [pfe_pkg::COLOR_W-1:0]     color;
      logic                            written;
      logic                            last;
      logic                            done;
      logic                            active;
   } fade_out_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_we = 1'b0;
   logic [pfe_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [pfe_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [23:0]                    req_tdata = '0;
   logic                           req_tuser = 1'b0;
   logic                           req_tlast = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [15:0]                    rsp_tdata;
   logic [2:0]                     rsp_tuser;
   logic                           rsp_tlast;

   // register mirror
   logic [pfe_pkg::COLOR_W-1:0] cfg_target = '0;
   logic [pfe_pkg::LEVEL_W-1:0] cfg_start = '0;
   logic [pfe_pkg::LEVEL_W-1:0] cfg_end = '0;
   logic [pfe_pkg::SPEED_W-1:0] cfg_speed = '0;
   logic [pfe_pkg::MASK_W-1:0]  cfg_mask = '0;

   // predictor state
   logic                        fading = 1'b0;
   logic [pfe_pkg::LEVEL_W-1:0] level = '0;
   logic [pfe_pkg::DELAY_W-1:0] delay_cnt = '0;
   logic                        pass_open = 1'b0;
   logic                        blending = 1'b0;
   logic [pfe_pkg::COLOR_W-1:0] lat_target = '0;
   logic [pfe_pkg::LEVEL_W-1:0] lat_end = '0;
   logic [pfe_pkg::STEP_W-1:0]  lat_step = '0;
   logic [pfe_pkg::DELAY_W-1:0] lat_delay = '0;
   logic                        lat_down = 1'b0;
   logic [pfe_pkg::MASK_W-1:0]  lat_mask = '0;

   pass_word_type palette_words[$];
   fade_out_type  predicted_words[$];
   int            words_queued = 0;
   int            errors = 0;

   // driver state
   pass_word_type on_bus;
   int            burst_left = 0;
   int            gap_left = 0;

   // receiver state
   logic [15:0] stall_cycle = '0;
   int          hold_left = 0;
   int          next_hold_at = 200;
   int          results_seen = 0;

   palette_fade_engine #(
      .SLOT_COUNT(SLOTS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // floor blend of one 5-bit channel, saturated
   function automatic logic [pfe_pkg::CHAN_W-1:0] blend_channel(
         logic [pfe_pkg::CHAN_W-1:0]  c,
         logic [pfe_pkg::CHAN_W-1:0]  t,
         logic [pfe_pkg::LEVEL_W-1:0] lv);
      int prod;
      int r;
      prod = (int'(t) - int'(c)) * int'(lv);
      r = int'(c) + (prod >>> 4);
      if (r < 0) r = 0;
      if (r > 31) r = 31;
      return r[pfe_pkg::CHAN_W-1:0];
   endfunction

   function automatic fade_out_type fade_compute(pass_word_type w);
      fade_out_type                      res;
      logic signed [pfe_pkg::SPEED_W-1:0] spd;
      int                                nxt;
      res = '0;
      if (!pass_open) begin
         blending = 1'b0;
         if (w.cmd == pfe_pkg::CMD_START) begin
            if (!fading) begin
               spd = cfg_speed;
               if (spd < 0) begin
                  lat_step = pfe_pkg::STEP_W'(2 - int'(spd));
                  lat_delay = '0;
               end else begin
                  lat_step = pfe_pkg::BASE_STEP;
                  lat_delay = spd[pfe_pkg::DELAY_W-1:0];
               end
               lat_target = cfg_target;
               lat_end = cfg_end;
               lat_down = !(cfg_start < cfg_end);
               lat_mask = (SLOTS >= 16) ? cfg_mask
                                        : (cfg_mask & pfe_pkg::MASK_W'((1 << SLOTS) - 1));
               level = cfg_start;
               delay_cnt = lat_delay;
               fading = 1'b1;
               blending = 1'b1;
            end
         end else if (fading) begin
            if (delay_cnt < lat_delay) begin
               delay_cnt = delay_cnt + 1'b1;
            end else begin
               delay_cnt = '0;
               blending = 1'b1;
            end
         end
         pass_open = 1'b1;
      end
      if (blending && int'(w.slot) < SLOTS && lat_mask[w.slot]) begin
         res.written = 1'b1;
         res.color = {blend_channel(w.color[14:10], lat_target[14:10], level),
                      blend_channel(w.color[9:5], lat_target[9:5], level),
                      blend_channel(w.color[4:0], lat_target[4:0], level)};
      end
      if (w.last) begin
         if (blending) begin
            if (level == lat_end) begin
               fading = 1'b0;
               res.done = 1'b1;
            end else if (!lat_down) begin
               nxt = int'(level) + int'(lat_step);
               level = (nxt > int'(lat_end)) ? lat_end : pfe_pkg::LEVEL_W'(nxt);
            end else if (int'(level) < int'(lat_end) + int'(lat_step)) begin
               level = lat_end;
            end else begin
               level = level - pfe_pkg::LEVEL_W'(lat_step);
            end
         end
         pass_open = 1'b0;
         blending = 1'b0;
      end
      res.last = w.last;
      res.active = fading;
      return res;
   endfunction

   function automatic void queue_word(pfe_pkg::cmd_type c, logic [pfe_pkg::SLOT_W-1:0] s,
                                      logic [pfe_pkg::COLOR_W-1:0] col, logic l);
      pass_word_type w;
      w.cmd = c;
      w.slot = s;
      w.color = col;
      w.last = l;
      palette_words.push_back(w);
      words_queued++;
   endfunction

   // one pass of random colours; later words may carry a different cmd
   function automatic void queue_pass(pfe_pkg::cmd_type first, int len, bit mixed);
      pfe_pkg::cmd_type            c;
      logic [pfe_pkg::COLOR_W-1:0] col;
      for (int i = 0; i < len; i++) begin
         c = (i > 0 && mixed) ? pfe_pkg::cmd_type'($urandom_range(0, 1)) : first;
         case ($urandom_range(0, 9))
            0: col = '0;
            1: col = '1;
            default: col = pfe_pkg::COLOR_W'($urandom_range(0, 32767));
         endcase
         queue_word(c, pfe_pkg::SLOT_W'($urandom_range(0, 15)), col, i == len - 1);
      end
   endfunction

   task automatic csr_write(pfe_pkg::csr_index_type idx,
                            logic [pfe_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         pfe_pkg::CSR_TARGET_COLOR: cfg_target = value[pfe_pkg::COLOR_W-1:0];
         pfe_pkg::CSR_START_LEVEL:  cfg_start = value[pfe_pkg::LEVEL_W-1:0];
         pfe_pkg::CSR_END_LEVEL:    cfg_end = value[pfe_pkg::LEVEL_W-1:0];
         pfe_pkg::CSR_FADE_SPEED:   cfg_speed = value[pfe_pkg::SPEED_W-1:0];
         pfe_pkg::CSR_SLOT_MASK:    cfg_mask = value[pfe_pkg::MASK_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // hold until every queued word is through and the result register is empty
   task automatic wait_drained();
      while (palette_words.size() != 0 || predicted_words.size() != 0 || req_tvalid)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_all(logic [pfe_pkg::COLOR_W-1:0] tgt, int st, int en, int spd,
                            logic [pfe_pkg::MASK_W-1:0] mask);
      csr_write(pfe_pkg::CSR_TARGET_COLOR, pfe_pkg::CSR_DATA_W'(tgt));
      csr_write(pfe_pkg::CSR_START_LEVEL, pfe_pkg::CSR_DATA_W'(st));
      csr_write(pfe_pkg::CSR_END_LEVEL, pfe_pkg::CSR_DATA_W'(en));
      csr_write(pfe_pkg::CSR_FADE_SPEED, pfe_pkg::CSR_DATA_W'(spd));
      csr_write(pfe_pkg::CSR_SLOT_MASK, pfe_pkg::CSR_DATA_W'(mask));
   endtask

   // driver: bursts of words with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready)
            predicted_words.push_back(fade_compute(on_bus));
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (palette_words.size() == 0) begin
               req_tvalid <= 1'b0;
            end else begin
               on_bus = palette_words.pop_front();
               req_tdata <= {5'b0, on_bus.color, on_bus.slot};
               req_tuser <= on_bus.cmd;
               req_tlast <= on_bus.last;
               req_tvalid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 60);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // monitor: check each result word, then pick the next ready
   always @(posedge clock) begin
      fade_out_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (predicted_words.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("unexpected result word: data %h user %b last %b",
                           rsp_tdata, rsp_tuser, rsp_tlast);
            end else begin
               want = predicted_words.pop_front();
               if (rsp_tdata !== {1'b0, want.color} ||
                   rsp_tuser !== {want.active, want.done, want.written} ||
                   rsp_tlast !== want.last) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display({"mismatch: expected color %h written %b done %b ",
                               "active %b last %b, got data %h user %b last %b"},
                              want.color, want.written, want.done, want.active,
                              want.last, rsp_tdata, rsp_tuser, rsp_tlast);
               end
            end
         end
         stall_cycle = stall_cycle + 1'b1;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (results_seen >= next_hold_at) begin
            // long hold-off so the block backs up into its input
            hold_left = 150;
            next_hold_at += 450;
            rsp_tready <= 1'b0;
         end else begin
            case (stall_cycle[8:7])
               2'd0: rsp_tready <= 1'b1;
               2'd1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2'd2: rsp_tready <= ($urandom_range(0, 2) == 0);
               default: rsp_tready <= (stall_cycle[1:0] != 2'd0);
            endcase
         end
      end
   end

   initial begin
      #400000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      int st;
      int en;
      int spd;
      int dly;
      int stp;
      int blends;
      int ticks;
      int len;
      int base;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // fastest step upward, full target, every slot; mixed cmd in a tick pass
      write_all(15'h7fff, 0, 16, -13, 16'hffff);
      queue_word(pfe_pkg::CMD_START, 4'd0, 15'h0000, 1'b0);
      queue_word(pfe_pkg::CMD_START, 4'd15, 15'h7fff, 1'b1);
      queue_word(pfe_pkg::CMD_TICK, 4'd0, 15'h0000, 1'b0);
      queue_word(pfe_pkg::CMD_START, 4'd15, 15'h001f, 1'b1);
      queue_word(pfe_pkg::CMD_TICK, 4'd7, 15'h4210, 1'b1);
      queue_word(pfe_pkg::CMD_TICK, 4'd3, 15'h1234, 1'b1);
      wait_drained();

      // level above sixteen saturates high; start while active is ignored
      write_all(15'h7fff, 31, 28, 0, 16'ha5a5);
      queue_word(pfe_pkg::CMD_START, 4'd0, 15'h0000, 1'b0);
      queue_word(pfe_pkg::CMD_START, 4'd2, 15'h7fff, 1'b0);
      queue_word(pfe_pkg::CMD_START, 4'd1, 15'h2a5f, 1'b1);
      queue_word(pfe_pkg::CMD_START, 4'd5, 15'h0421, 1'b1);
      queue_word(pfe_pkg::CMD_TICK, 4'd8, 15'h1111, 1'b1);
      queue_word(pfe_pkg::CMD_TICK, 4'd15, 15'h7c00, 1'b1);
      wait_drained();

      // saturation toward zero and a delay of two ticks between blends
      write_all(15'h0000, 20, 16, 2, 16'h8001);
      queue_word(pfe_pkg::CMD_START, 4'd15, 15'h7fff, 1'b1);
      queue_word(pfe_pkg::CMD_TICK, 4'd0, 15'h3def, 1'b1);
      queue_word(pfe_pkg::CMD_TICK, 4'd1, 15'h0001, 1'b1);
      queue_word(pfe_pkg::CMD_TICK, 4'd15, 15'h5555, 1'b1);
      queue_word(pfe_pkg::CMD_TICK, 4'd0, 15'h7fff, 1'b1);
      wait_drained();

      // empty selection, longest delay, start level already at the end
      write_all(15'h1234, 4, 4, 63, 16'h0000);
      queue_word(pfe_pkg::CMD_START, 4'd9, 15'h6b5a, 1'b0);
      queue_word(pfe_pkg::CMD_START, 4'd0, 15'h7fff, 1'b1);
      queue_word(pfe_pkg::CMD_TICK, 4'd2, 15'h0000, 1'b1);

      base = words_queued;
      while (words_queued < base + RANDOM_WORDS) begin
         wait_drained();
         case ($urandom_range(0, 9))
            0, 1, 2: spd = -int'($urandom_range(1, 13));
            3, 4, 5, 6, 7: spd = $urandom_range(0, 3);
            8: spd = $urandom_range(4, 15);
            default: spd = $urandom_range(16, 63);
         endcase
         dly = (spd < 0) ? 0 : spd;
         stp = (spd < 0) ? 2 - spd : 2;
         st = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
         en = ($urandom_range(0, 11) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
         // slow fades stay short: three blends are enough to see the delay
         if (dly > 15) begin
            st = $urandom_range(0, 16);
            en = (st >= 4) ? st - 4 : st + 4;
         end
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 5))
               0: csr_write(pfe_pkg::CSR_TARGET_COLOR, 16'h0000);
               1: csr_write(pfe_pkg::CSR_TARGET_COLOR, 16'h7fff);
               default: csr_write(pfe_pkg::CSR_TARGET_COLOR,
                                  pfe_pkg::CSR_DATA_W'($urandom_range(0, 32767)));
            endcase
         end
         csr_write(pfe_pkg::CSR_START_LEVEL, pfe_pkg::CSR_DATA_W'(st));
         csr_write(pfe_pkg::CSR_END_LEVEL, pfe_pkg::CSR_DATA_W'(en));
         csr_write(pfe_pkg::CSR_FADE_SPEED, pfe_pkg::CSR_DATA_W'(spd));
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 5))
               0: csr_write(pfe_pkg::CSR_SLOT_MASK, 16'h0000);
               1: csr_write(pfe_pkg::CSR_SLOT_MASK, 16'hffff);
               default: csr_write(pfe_pkg::CSR_SLOT_MASK,
                                  pfe_pkg::CSR_DATA_W'($urandom_range(0, 65535)));
            endcase
         end

         blends = ((st > en ? st - en : en - st) + stp - 1) / stp + 1;
         ticks = blends * (dly + 1) + $urandom_range(0, 2);
         if ($urandom_range(0, 3) == 0)
            queue_pass(pfe_pkg::CMD_TICK, $urandom_range(1, 4), 1'b0);
         queue_pass(pfe_pkg::CMD_START, $urandom_range(1, 8), 1'b0);
         for (int i = 0; i < ticks; i++) begin
            if (dly > 3)
               len = $urandom_range(1, 2);
            else if ($urandom_range(0, 15) == 0)
               len = 16;
            else
               len = $urandom_range(1, 8);
            case ($urandom_range(0, 19))
               0: queue_pass(pfe_pkg::CMD_START, len, 1'b0);
               1, 2: queue_pass(pfe_pkg::CMD_TICK, len, 1'b1);
               3: queue_pass(pfe_pkg::CMD_START, len, 1'b1);
               default: queue_pass(pfe_pkg::CMD_TICK, len, 1'b0);
            endcase
         end
      end

      wait_drained();
      repeat (16) @(posedge clock);
      if (errors == 0 && predicted_words.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/pfe_pkg.sv
hdl/palette_fade_engine.sv
tb/tb_palette_fade_engine.sv
